### rtl/isfc_pkg.sv
`default_nettype none

package isfc_pkg;

  localparam int unsigned BUF_DEPTH = 10;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [3:0] COUNT_MAX = 4'd15;
  localparam logic [3:0] IMU_FRAME_LEN = 4'd10;
  localparam logic [3:0] STATUS_FRAME_LEN = 4'd8;
  localparam logic [15:0] MODE_COUNT = 16'd4;

  localparam logic [7:0] HDR_IMU = 8'hAA;
  localparam logic [7:0] HDR_STATUS = 8'hBB;
  localparam logic [7:0] TAIL_IMU = 8'hDD;

  // accepted window for the raw squared norm: 1e8 +/- 1e7
  localparam logic [32:0] NORM_LO = 33'd90000000;
  localparam logic [32:0] NORM_HI = 33'd110000000;

  typedef enum logic [2:0] {
    ST_IMU_OK    = 3'd0,
    ST_STATUS_OK = 3'd1,
    ST_EMPTY     = 3'd2,
    ST_BAD_LEN   = 3'd3,
    ST_BAD_TAIL  = 3'd4,
    ST_BAD_NORM  = 3'd5,
    ST_UNKNOWN   = 3'd6
  } frame_status_e;

  typedef struct packed {
    logic [7:0]  rx_byte;
    logic        byte_valid;
    logic        frame_end;
    logic [31:0] arrival_time;
  } in_item_t;

  typedef struct packed {
    logic [2:0]         frame_status;
    logic signed [15:0] quat_w;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
    logic [31:0]        quat_time;
    logic signed [15:0] speed_raw;
    logic [3:0]         mode_now;
    logic signed [15:0] angle_raw;
  } out_item_t;

  // One closed frame as classified by the front end. For an IMU frame the
  // words are x,y,z,w; for a status frame speed,mode,angle and a spare.
  typedef struct packed {
    frame_status_e      kind;
    logic [3:0][15:0]   word;
    logic [31:0]        arrival_time;
  } frame_entry_t;

endpackage

`default_nettype wire

### rtl/imu_status_frame_checker_top.sv
// IMU / status frame checker.
// Input channel: one received byte per transfer (in_valid_i / in_stall_o,
// payload in_data_i). byte_valid low carries no byte; frame_end closes the
// current frame, including a byte on the same transfer.
// Output channel: one result per closed frame (out_valid_o / out_stall_i,
// payload out_data_o): frame status, quaternion and time stamp for a good
// IMU frame, and the stored speed, mode and angle after the frame.
// Transfers that do not close a frame give no result.
// Throughput: one input transfer per cycle while in_stall_o is low. The front
// end collects bytes and classifies the frame at its end, a two-entry queue
// feeds the back end, which squares the quaternion parts in one stage and
// checks the norm and updates the stored values in the output stage.
// A closing transfer's result passes through the queue, the square stage and
// the output register.
// When the receiver stalls, the output register holds its result, the square
// stage and queue fill, and in_stall_o rises once the queue is full.
// Reset clears the byte count, the pipeline and the stored speed, mode
// and angle to zero; no clearing pass is needed.
`default_nettype none

module imu_status_frame_checker_top (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire isfc_pkg::in_item_t  in_data_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output isfc_pkg::out_item_t      out_data_o
);

  logic                   q_full;
  logic                   q_push;
  logic                   q_pop;
  logic                   q_valid;
  isfc_pkg::frame_entry_t q_entry;
  isfc_pkg::frame_entry_t q_head;

  isfc_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_entry_o  (q_entry)
  );

  isfc_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (q_push),
    .push_entry_i (q_entry),
    .full_o       (q_full),
    .pop_i        (q_pop),
    .valid_o      (q_valid),
    .head_o       (q_head)
  );

  isfc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_pop_o     (q_pop),
    .q_head_i    (q_head),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

### rtl/isfc_front.sv
`default_nettype none

module isfc_front (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    in_valid_i,
  output logic                         in_stall_o,
  input  wire isfc_pkg::in_item_t      in_data_i,
  input  wire logic                    q_full_i,
  output logic                         q_push_o,
  output isfc_pkg::frame_entry_t       q_entry_o
);

  logic [7:0] bytes_q [isfc_pkg::BUF_DEPTH];
  logic [7:0] view    [isfc_pkg::BUF_DEPTH];
  logic [3:0] count_q;
  logic [3:0] count_d;
  logic [3:0] count_new;
  logic       accept;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign q_push_o   = accept && in_data_i.frame_end;

  // frame contents including a byte carried on this transfer
  always_comb begin
    for (int k = 0; k < int'(isfc_pkg::BUF_DEPTH); k++) begin
      view[k] = (in_data_i.byte_valid && count_q == 4'(k)) ? in_data_i.rx_byte : bytes_q[k];
    end
    if (in_data_i.byte_valid && count_q != isfc_pkg::COUNT_MAX) begin
      count_new = count_q + 4'd1;
    end else begin
      count_new = count_q;
    end
    count_d = in_data_i.frame_end ? 4'd0 : count_new;
  end

  always_comb begin
    q_entry_o.arrival_time = in_data_i.arrival_time;
    q_entry_o.word[0] = {view[2], view[1]};
    q_entry_o.word[1] = {view[4], view[3]};
    q_entry_o.word[2] = {view[6], view[5]};
    q_entry_o.word[3] = {view[8], view[7]};
    if (count_new == 4'd0) begin
      q_entry_o.kind = isfc_pkg::ST_EMPTY;
    end else if (view[0] == isfc_pkg::HDR_IMU) begin
      if (count_new != isfc_pkg::IMU_FRAME_LEN) begin
        q_entry_o.kind = isfc_pkg::ST_BAD_LEN;
      end else if (view[isfc_pkg::BUF_DEPTH - 1] != isfc_pkg::TAIL_IMU) begin
        q_entry_o.kind = isfc_pkg::ST_BAD_TAIL;
      end else begin
        // norm still to be checked in the back end
        q_entry_o.kind = isfc_pkg::ST_IMU_OK;
      end
    end else if (view[0] == isfc_pkg::HDR_STATUS) begin
      if (count_new != isfc_pkg::STATUS_FRAME_LEN) begin
        q_entry_o.kind = isfc_pkg::ST_BAD_LEN;
      end else begin
        q_entry_o.kind = isfc_pkg::ST_STATUS_OK;
      end
    end else begin
      q_entry_o.kind = isfc_pkg::ST_UNKNOWN;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= 4'd0;
    end else if (accept) begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      bytes_q <= view;
    end
  end

endmodule

`default_nettype wire

### rtl/isfc_queue.sv
`default_nettype none

module isfc_queue (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    push_i,
  input  wire isfc_pkg::frame_entry_t  push_entry_i,
  output logic                         full_o,
  input  wire logic                    pop_i,
  output logic                         valid_o,
  output isfc_pkg::frame_entry_t       head_o
);

  localparam int unsigned PtrW = $clog2(isfc_pkg::QUEUE_DEPTH);
  localparam int unsigned CntW = $clog2(isfc_pkg::QUEUE_DEPTH + 1);

  isfc_pkg::frame_entry_t mem_q [isfc_pkg::QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr_q;
  logic [PtrW-1:0] rd_ptr_q;
  logic [CntW-1:0] fill_q;

  assign full_o  = fill_q == CntW'(isfc_pkg::QUEUE_DEPTH);
  assign valid_o = fill_q != '0;
  assign head_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(isfc_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(isfc_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        fill_q <= fill_q + 1'b1;
      end else if (pop_i && !push_i) begin
        fill_q <= fill_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_entry_i;
    end
  end

endmodule

`default_nettype wire

### rtl/isfc_back.sv
`default_nettype none

module isfc_back (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    q_valid_i,
  output logic                         q_pop_o,
  input  wire isfc_pkg::frame_entry_t  q_head_i,
  output logic                         out_valid_o,
  input  wire logic                    out_stall_i,
  output isfc_pkg::out_item_t          out_data_o
);

  // square stage
  logic                   sq_valid_q;
  isfc_pkg::frame_entry_t sq_entry_q;
  logic [30:0]            sq_q [4];
  logic [30:0]            sq_d [4];
  logic                   sq_ready;

  // output stage and stored status values
  logic                   out_valid_q;
  isfc_pkg::out_item_t    out_q;
  isfc_pkg::out_item_t    out_d;
  logic                   out_ready;
  logic                   load_out;
  logic [15:0]            speed_q, speed_d;
  logic [3:0]             mode_q, mode_d;
  logic [15:0]            angle_q, angle_d;
  logic [32:0]            norm_sum;
  logic                   norm_ok;
  logic                   is_status;
  isfc_pkg::frame_status_e status;

  assign out_ready   = !out_valid_q || !out_stall_i;
  assign sq_ready    = !sq_valid_q || out_ready;
  assign q_pop_o     = q_valid_i && sq_ready;
  assign load_out    = sq_valid_q && out_ready;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    logic signed [31:0] prod;
    prod = '0;
    for (int k = 0; k < 4; k++) begin
      prod    = $signed(q_head_i.word[k]) * $signed(q_head_i.word[k]);
      sq_d[k] = prod[30:0];
    end
  end

  always_comb begin
    norm_sum = 33'(sq_q[0]) + 33'(sq_q[1]) + 33'(sq_q[2]) + 33'(sq_q[3]);
    norm_ok  = norm_sum >= isfc_pkg::NORM_LO && norm_sum <= isfc_pkg::NORM_HI;
    is_status = sq_entry_q.kind == isfc_pkg::ST_STATUS_OK;
    if (sq_entry_q.kind == isfc_pkg::ST_IMU_OK && !norm_ok) begin
      status = isfc_pkg::ST_BAD_NORM;
    end else begin
      status = sq_entry_q.kind;
    end
  end

  always_comb begin
    speed_d = speed_q;
    mode_d  = mode_q;
    angle_d = angle_q;
    if (load_out && is_status) begin
      speed_d = sq_entry_q.word[0];
      angle_d = sq_entry_q.word[2];
      // negative modes and modes at or past the count leave the mode alone
      if (!sq_entry_q.word[1][15] && sq_entry_q.word[1] < isfc_pkg::MODE_COUNT) begin
        mode_d = sq_entry_q.word[1][3:0];
      end
    end
  end

  always_comb begin
    out_d              = '0;
    out_d.frame_status = status;
    if (status == isfc_pkg::ST_IMU_OK) begin
      out_d.quat_x    = sq_entry_q.word[0];
      out_d.quat_y    = sq_entry_q.word[1];
      out_d.quat_z    = sq_entry_q.word[2];
      out_d.quat_w    = sq_entry_q.word[3];
      out_d.quat_time = sq_entry_q.arrival_time;
    end
    out_d.speed_raw = speed_d;
    out_d.mode_now  = mode_d;
    out_d.angle_raw = angle_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      speed_q     <= '0;
      mode_q      <= '0;
      angle_q     <= '0;
    end else begin
      if (sq_ready) begin
        sq_valid_q <= q_valid_i;
      end
      if (out_ready) begin
        out_valid_q <= sq_valid_q;
      end
      speed_q <= speed_d;
      mode_q  <= mode_d;
      angle_q <= angle_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      sq_entry_q <= q_head_i;
      sq_q       <= sq_d;
    end
    if (load_out) begin
      out_q <= out_d;
    end
  end

endmodule

`default_nettype wire

### bench/tb_imu_status_frame_checker_top.sv
`default_nettype none

module tb_imu_status_frame_checker_top;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  isfc_pkg::in_item_t  in_data_i = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  isfc_pkg::out_item_t out_data_o;

  imu_status_frame_checker_top uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  // byte items waiting to be sent, and decoded frames waiting to come out
  isfc_pkg::in_item_t  rx_items [$];
  isfc_pkg::out_item_t frames_due [$];
  logic [7:0]          frame_build [$];

  int unsigned rx_total;
  int unsigned accepted_items = 0;
  int unsigned counted_items = 0;
  int unsigned mismatch_count = 0;
  int unsigned send_hold = 0;
  int unsigned stall_left = 0;

  // predictor state
  logic [7:0]  frm_buf [isfc_pkg::BUF_DEPTH];
  logic [3:0]  frm_count = '0;
  logic [15:0] speed_q = '0;
  logic [3:0]  mode_q = '0;
  logic [15:0] angle_q = '0;

  // stretches without idling on either side
  logic        calm_in = 1'b0;
  logic        calm_out = 1'b0;
  int unsigned calm_left = 0;

  isfc_pkg::out_item_t due_r;

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  initial begin
    #2000000;
    $display("RESULT: ERROR");
    $finish;
  end

  task automatic decode_frame_item(input isfc_pkg::in_item_t it);
    isfc_pkg::out_item_t r;
    logic [3:0]          n;
    logic signed [15:0]  qx, qy, qz, qw;
    logic [15:0]         mode_word;
    longint              sumsq;
    if (it.byte_valid) begin
      if (frm_count < isfc_pkg::BUF_DEPTH) frm_buf[frm_count] = it.rx_byte;
      if (frm_count < isfc_pkg::COUNT_MAX) frm_count = frm_count + 4'd1;
    end
    if (it.frame_end) begin
      n = frm_count;
      frm_count = '0;
      r = '0;
      if (n == 4'd0) begin
        r.frame_status = isfc_pkg::ST_EMPTY;
      end else if (frm_buf[0] == isfc_pkg::HDR_IMU) begin
        if (n != isfc_pkg::IMU_FRAME_LEN) begin
          r.frame_status = isfc_pkg::ST_BAD_LEN;
        end else if (frm_buf[isfc_pkg::IMU_FRAME_LEN - 1] != isfc_pkg::TAIL_IMU) begin
          r.frame_status = isfc_pkg::ST_BAD_TAIL;
        end else begin
          qx = {frm_buf[2], frm_buf[1]};
          qy = {frm_buf[4], frm_buf[3]};
          qz = {frm_buf[6], frm_buf[5]};
          qw = {frm_buf[8], frm_buf[7]};
          // exact on raw integers: four int16 squares can reach 2^32
          sumsq = longint'(qx) * qx + longint'(qy) * qy
                + longint'(qz) * qz + longint'(qw) * qw;
          if (sumsq < longint'(isfc_pkg::NORM_LO) ||
              sumsq > longint'(isfc_pkg::NORM_HI)) begin
            r.frame_status = isfc_pkg::ST_BAD_NORM;
          end else begin
            r.frame_status = isfc_pkg::ST_IMU_OK;
            r.quat_x = qx;
            r.quat_y = qy;
            r.quat_z = qz;
            r.quat_w = qw;
            r.quat_time = it.arrival_time;
          end
        end
      end else if (frm_buf[0] == isfc_pkg::HDR_STATUS) begin
        if (n != isfc_pkg::STATUS_FRAME_LEN) begin
          r.frame_status = isfc_pkg::ST_BAD_LEN;
        end else begin
          speed_q = {frm_buf[2], frm_buf[1]};
          mode_word = {frm_buf[4], frm_buf[3]};
          if (!mode_word[15] && mode_word < isfc_pkg::MODE_COUNT) mode_q = mode_word[3:0];
          angle_q = {frm_buf[6], frm_buf[5]};
          r.frame_status = isfc_pkg::ST_STATUS_OK;
        end
      end else begin
        r.frame_status = isfc_pkg::ST_UNKNOWN;
      end
      r.speed_raw = speed_q;
      r.mode_now = mode_q;
      r.angle_raw = angle_q;
      frames_due = {frames_due, r};
    end
  endtask

  task automatic put16(input logic [15:0] v);
    frame_build = {frame_build, v[7:0]};
    frame_build = {frame_build, v[15:8]};
  endtask

  // frame_build goes out as byte transfers, with stray empty items in between;
  // the closing mark rides on the last byte or on an empty item of its own
  task automatic send_frame();
    isfc_pkg::in_item_t it;
    logic               close_on_byte;
    close_on_byte = (frame_build.size() > 0) && ($urandom_range(0, 3) != 0);
    for (int i = 0; i < frame_build.size(); i++) begin
      if ($urandom_range(0, 15) == 0) begin
        it.rx_byte = 8'($urandom);
        it.byte_valid = 1'b0;
        it.frame_end = 1'b0;
        it.arrival_time = $urandom;
        rx_items = {rx_items, it};
      end
      it.rx_byte = frame_build[i];
      it.byte_valid = 1'b1;
      it.frame_end = close_on_byte && (i == frame_build.size() - 1);
      it.arrival_time = $urandom;
      rx_items = {rx_items, it};
      counted_items++;
    end
    if (!close_on_byte) begin
      it.rx_byte = 8'($urandom);
      it.byte_valid = 1'b0;
      it.frame_end = 1'b1;
      it.arrival_time = $urandom;
      rx_items = {rx_items, it};
      counted_items++;
    end
    frame_build = {};
  endtask

  task automatic build_stimulus();
    isfc_pkg::in_item_t it;
    int                 x, y, z, w, tgt, rem;
    int unsigned        kind, len, pick;
    logic [7:0]         hdr;
    logic [15:0]        mode_word;

    // directed: empty, unknown header, short IMU, short status
    send_frame();
    frame_build = {frame_build, 8'hFF};
    send_frame();
    frame_build = {frame_build, isfc_pkg::HDR_IMU};
    send_frame();
    frame_build = {frame_build, isfc_pkg::HDR_STATUS};
    send_frame();
    // status at field extremes, top legal mode
    frame_build = {frame_build, isfc_pkg::HDR_STATUS};
    put16(16'h8000);
    put16(isfc_pkg::MODE_COUNT - 16'd1);
    put16(16'h7FFF);
    frame_build = {frame_build, 8'h00};
    send_frame();
    // all parts at -32768: sum of squares is exactly 2^32
    frame_build = {frame_build, isfc_pkg::HDR_IMU};
    repeat (4) put16(16'h8000);
    frame_build = {frame_build, isfc_pkg::TAIL_IMU};
    send_frame();

    while (counted_items < 1700) begin
      kind = $urandom_range(0, 99);
      if (kind < 47) begin
        // quaternion aimed around unit norm, most of them inside the window
        tgt = 100000000 + int'($urandom_range(0, 24000000)) - 12000000;
        x = int'($urandom_range(0, 12000)) - 6000;
        y = int'($urandom_range(0, 12000)) - 6000;
        z = int'($urandom_range(0, 12000)) - 6000;
        rem = tgt - x * x - y * y - z * z;
        w = (rem > 0) ? $rtoi($sqrt(real'(rem))) : 0;
        if ($urandom_range(0, 1) == 1) w = -w;
        frame_build = {frame_build, isfc_pkg::HDR_IMU};
        put16(x[15:0]);
        put16(y[15:0]);
        put16(z[15:0]);
        put16(w[15:0]);
        if (kind < 40) begin
          frame_build = {frame_build, isfc_pkg::TAIL_IMU};
        end else begin
          hdr = 8'($urandom);
          if (hdr == isfc_pkg::TAIL_IMU) hdr = 8'h00;
          frame_build = {frame_build, hdr};
        end
      end else if (kind < 70) begin
        pick = $urandom_range(0, 99);
        if (pick < 70) mode_word = 16'($urandom_range(0, isfc_pkg::MODE_COUNT - 1));
        else if (pick < 85)
          mode_word = 16'($urandom_range(isfc_pkg::MODE_COUNT, 16'h7FFF));
        else mode_word = 16'($urandom_range(16'h8000, 16'hFFFF));
        frame_build = {frame_build, isfc_pkg::HDR_STATUS};
        put16(16'($urandom));
        put16(mode_word);
        put16(16'($urandom));
        frame_build = {frame_build, 8'($urandom)};
      end else if (kind < 79) begin
        // wrong length, the longest ones run the count into saturation
        hdr = ($urandom_range(0, 1) == 1) ? isfc_pkg::HDR_IMU : isfc_pkg::HDR_STATUS;
        len = $urandom_range(1, 18);
        if (hdr == isfc_pkg::HDR_IMU && len == isfc_pkg::IMU_FRAME_LEN) len++;
        if (hdr == isfc_pkg::HDR_STATUS && len == isfc_pkg::STATUS_FRAME_LEN) len++;
        frame_build = {frame_build, hdr};
        repeat (len - 1) frame_build = {frame_build, 8'($urandom)};
      end else if (kind < 86) begin
        hdr = 8'($urandom);
        if (hdr == isfc_pkg::HDR_IMU || hdr == isfc_pkg::HDR_STATUS) hdr = hdr ^ 8'h01;
        len = $urandom_range(1, 12);
        frame_build = {frame_build, hdr};
        repeat (len - 1) frame_build = {frame_build, 8'($urandom)};
      end else if (kind < 90) begin
        send_frame();
      end else begin
        repeat ($urandom_range(1, 6)) begin
          it.rx_byte = 8'($urandom);
          it.byte_valid = 1'($urandom_range(0, 1));
          it.frame_end = ($urandom_range(0, 3) == 0);
          it.arrival_time = $urandom;
          rx_items = {rx_items, it};
          if (it.byte_valid || it.frame_end) counted_items++;
        end
      end
      if (frame_build.size() > 0) send_frame();
    end
  endtask

  function automatic int unsigned draw_gap(input logic calm);
    return calm ? 0 : $urandom_range(0, 16);
  endfunction

  task automatic check_field(input string fname, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("mismatch %s: expected %h got %h", fname, want, got);
    end
  endtask

  always @(posedge clk_i) begin
    if (calm_left == 0) begin
      calm_left <= $urandom_range(50, 400);
      calm_in <= ($urandom_range(0, 3) == 0);
      calm_out <= ($urandom_range(0, 3) == 0);
    end else begin
      calm_left <= calm_left - 1;
    end
  end

  // input driver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      send_hold = draw_gap(calm_in);
    end else begin
      if (in_valid_i && !in_stall_o) begin
        decode_frame_item(in_data_i);
        accepted_items++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (send_hold > 0) begin
          send_hold--;
          in_valid_i <= 1'b0;
        end else if (rx_items.size() > 0) begin
          in_data_i <= rx_items[0];
          rx_items.delete(0);
          in_valid_i <= 1'b1;
          send_hold = draw_gap(calm_in);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // output monitor
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (frames_due.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("unexpected result: status %0d", out_data_o.frame_status);
        end else begin
          due_r = frames_due[0];
          frames_due.delete(0);
          check_field("frame_status", due_r.frame_status, out_data_o.frame_status);
          check_field("quat_w", due_r.quat_w, out_data_o.quat_w);
          check_field("quat_x", due_r.quat_x, out_data_o.quat_x);
          check_field("quat_y", due_r.quat_y, out_data_o.quat_y);
          check_field("quat_z", due_r.quat_z, out_data_o.quat_z);
          check_field("quat_time", due_r.quat_time, out_data_o.quat_time);
          check_field("speed_raw", due_r.speed_raw, out_data_o.speed_raw);
          check_field("mode_now", due_r.mode_now, out_data_o.mode_now);
          check_field("angle_raw", due_r.angle_raw, out_data_o.angle_raw);
        end
        stall_left = draw_gap(calm_out);
      end else if (out_valid_o && stall_left > 0) begin
        stall_left--;
      end
      out_stall_i <= (stall_left > 0);
    end
  end

  initial begin
    for (int i = 0; i < int'(isfc_pkg::BUF_DEPTH); i++) frm_buf[i] = '0;
    build_stimulus();
    rx_total = rx_items.size();
    while (accepted_items < rx_total) @(negedge clk_i);
    while (frames_due.size() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
    if (mismatch_count == 0 && frames_due.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
